### rtl/arrive_steering_defines.svh
// assertion macros for the arrive steering block
// used by rtl/arrive_steering.sv, no other dependencies
`ifndef ARRIVE_STEERING_DEFINES_SVH
`define ARRIVE_STEERING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ARST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arrive steering check failed");

// next-cycle implication, disabled during reset
`define ARST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arrive steering check failed");

`endif

### rtl/arst_pkg.sv
// shared types, constants and helpers of the arrive steering block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arst_pkg;

   localparam int DIV_STEPS  = 31;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_NUM_W  = DIV_DEN_W + DIV_STEPS;
   localparam int ROOT_STEPS = 32;
   localparam int ROOT_RAD_W = 2 * ROOT_STEPS;
   // pipeline depth: the root and divide stages plus the registers outside them
   localparam int LATENCY    = 2 * ROOT_STEPS + 4 * DIV_STEPS + 13;

   localparam logic [30:0] MAX_ACCEL_RESET   = 31'd65536;
   localparam logic [30:0] MAX_SPEED_RESET   = 31'd65536;
   localparam logic [30:0] STOP_RADIUS_RESET = 31'd65536;
   localparam logic [30:0] SLOW_RADIUS_RESET = 31'd327680;
   localparam logic [30:0] TTT_RESET         = 31'd6554;

   localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [2:0] {
      CSR_MAX_ACCEL   = 3'd0,
      CSR_MAX_SPEED   = 3'd1,
      CSR_STOP_RADIUS = 3'd2,
      CSR_SLOW_RADIUS = 3'd3,
      CSR_TTT         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             v;
      logic [2:0][31:0] off;
      logic [2:0][31:0] vel;
   } geo_type;

   typedef struct packed {
      logic             v;
      logic             arr;
      logic             gt_slow;
      logic             slow_zero;
      logic [31:0]      dist_len;
      logic [2:0][31:0] off;
      logic [2:0][31:0] vel;
   } speed_side_type;

   typedef struct packed {
      logic             v;
      logic             arr;
      logic             dist_zero;
      logic [2:0]       neg;
      logic [2:0][31:0] vel;
   } want_side_type;

   typedef struct packed {
      logic             v;
      logic             arr;
      logic [2:0][32:0] err;
   } err_stage_type;

   typedef struct packed {
      logic       v;
      logic       arr;
      logic [2:0] neg;
      logic [2:0] ovf;
   } lin_side_type;

   typedef struct packed {
      logic             v;
      logic             arr;
      logic [2:0][31:0] lin;
   } lin_stage_type;

   typedef struct packed {
      logic             v;
      logic             arr;
      logic             clamp;
      logic [2:0][31:0] lin;
   } acc_side_type;

   function automatic logic [31:0] abs32(input logic [31:0] a);
      return a[31] ? (32'd0 - a) : a;
   endfunction

   // a - b saturated to the signed 32-bit range
   function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         return d[32] ? SAT_NEG : SAT_POS;
      end
      return d[31:0];
   endfunction

   // apply a sign to an unsigned quotient below 2^31
   function automatic logic [31:0] signed_q(input logic [30:0] q, input logic neg);
      return neg ? (32'd0 - {1'b0, q}) : {1'b0, q};
   endfunction

endpackage

`default_nettype wire

### rtl/arst_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on arst_pkg; quotient must fit in DIV_STEPS bits
`timescale 1ns / 1ps
`default_nettype none

module arst_div (
   input  logic                          clock,
   input  logic [arst_pkg::DIV_NUM_W-1:0] num_in,
   input  logic [arst_pkg::DIV_DEN_W-1:0] den_in,
   output logic [arst_pkg::DIV_STEPS-1:0] quo_out
);

   logic [arst_pkg::DIV_DEN_W-1:0] rem_ff [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_DEN_W-1:0] rem_in [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_STEPS-1:0] low_ff [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_STEPS-1:0] low_in [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_DEN_W-1:0] den_ff [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_DEN_W-1:0] den_in_s [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_STEPS-1:0] quo_ff [arst_pkg::DIV_STEPS];
   logic [arst_pkg::DIV_STEPS-1:0] quo_in [arst_pkg::DIV_STEPS];

   always_comb begin
      logic [arst_pkg::DIV_DEN_W-1:0] rem;
      logic [arst_pkg::DIV_STEPS-1:0] low;
      logic [arst_pkg::DIV_DEN_W-1:0] den;
      logic [arst_pkg::DIV_STEPS-1:0] quo;
      logic [arst_pkg::DIV_DEN_W:0]   trial;
      logic [arst_pkg::DIV_DEN_W:0]   diff;
      for (int k = 0; k < arst_pkg::DIV_STEPS; k++) begin
         if (k == 0) begin
            rem = num_in[arst_pkg::DIV_NUM_W-1:arst_pkg::DIV_STEPS];
            low = num_in[arst_pkg::DIV_STEPS-1:0];
            den = den_in;
            quo = '0;
         end else begin
            rem = rem_ff[k-1];
            low = low_ff[k-1];
            den = den_ff[k-1];
            quo = quo_ff[k-1];
         end
         trial = {rem, low[arst_pkg::DIV_STEPS-1]};
         diff  = trial - {1'b0, den};
         if (trial >= {1'b0, den}) begin
            rem_in[k] = diff[arst_pkg::DIV_DEN_W-1:0];
            quo_in[k] = {quo[arst_pkg::DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[arst_pkg::DIV_DEN_W-1:0];
            quo_in[k] = {quo[arst_pkg::DIV_STEPS-2:0], 1'b0};
         end
         low_in[k]   = {low[arst_pkg::DIV_STEPS-2:0], 1'b0};
         den_in_s[k] = den;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in_s;
      quo_ff <= quo_in;
   end

   assign quo_out = quo_ff[arst_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/arst_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on arst_pkg
`timescale 1ns / 1ps
`default_nettype none

module arst_sqrt (
   input  logic                           clock,
   input  logic [arst_pkg::ROOT_RAD_W-1:0] rad_in,
   output logic [arst_pkg::ROOT_STEPS-1:0] root_out
);

   localparam int REM_W = arst_pkg::ROOT_STEPS + 2;

   logic [REM_W-1:0]                rem_ff  [arst_pkg::ROOT_STEPS];
   logic [REM_W-1:0]                rem_in  [arst_pkg::ROOT_STEPS];
   logic [arst_pkg::ROOT_RAD_W-1:0] low_ff  [arst_pkg::ROOT_STEPS];
   logic [arst_pkg::ROOT_RAD_W-1:0] low_in  [arst_pkg::ROOT_STEPS];
   logic [arst_pkg::ROOT_STEPS-1:0] root_ff [arst_pkg::ROOT_STEPS];
   logic [arst_pkg::ROOT_STEPS-1:0] root_in [arst_pkg::ROOT_STEPS];

   always_comb begin
      logic [REM_W-1:0]                rem;
      logic [arst_pkg::ROOT_RAD_W-1:0] low;
      logic [arst_pkg::ROOT_STEPS-1:0] root;
      logic [REM_W+1:0]                shifted;
      logic [REM_W+1:0]                trial;
      logic [REM_W+1:0]                diff;
      for (int k = 0; k < arst_pkg::ROOT_STEPS; k++) begin
         if (k == 0) begin
            rem  = '0;
            low  = rad_in;
            root = '0;
         end else begin
            rem  = rem_ff[k-1];
            low  = low_ff[k-1];
            root = root_ff[k-1];
         end
         shifted = {rem, low[arst_pkg::ROOT_RAD_W-1:arst_pkg::ROOT_RAD_W-2]};
         trial   = {2'b00, root, 2'b01};
         diff    = shifted - trial;
         if (shifted >= trial) begin
            rem_in[k]  = diff[REM_W-1:0];
            root_in[k] = {root[arst_pkg::ROOT_STEPS-2:0], 1'b1};
         end else begin
            rem_in[k]  = shifted[REM_W-1:0];
            root_in[k] = {root[arst_pkg::ROOT_STEPS-2:0], 1'b0};
         end
         low_in[k] = {low[arst_pkg::ROOT_RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      root_ff <= root_in;
   end

   assign root_out = root_ff[arst_pkg::ROOT_STEPS-1];

endmodule

`default_nettype wire

### rtl/arrive_steering.sv
// arrive steering top level: pipeline, config registers and checks
// depends on arst_pkg, arst_div, arst_sqrt and arrive_steering_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "arrive_steering_defines.svh"

// arrive steering, signed q16.16 throughout
// input channel: goal, position and velocity vectors on req_*; a transfer
//   happens at a rising edge with start high and busy low. busy is always
//   low, so one agent can be taken in every cycle
// result channel: rsp_valid marks one cycle holding accel and arrived; the
//   receiver cannot hold results off, and none is needed since the pipeline
//   never stalls
// throughput: one item per cycle; the pipeline holds two 32-stage square
//   roots (distance, accel magnitude) and four 31-stage dividers in series
//   (target speed, direction, time to target, accel rescale), one result
//   bit per stage
// configuration: csr_we writes register csr_index with csr_wdata; unknown
//   indexes are dropped. write only while the pipe is empty
// reset: synchronous, clears all stage valid bits and loads register
//   defaults; items in flight are dropped

module arrive_steering (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_goal_x,
   input  logic signed [31:0] req_goal_y,
   input  logic signed [31:0] req_goal_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_accel_x,
   output logic signed [31:0] rsp_accel_y,
   output logic signed [31:0] rsp_accel_z,
   output logic               rsp_arrived,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   // ---------------------------------------------------------------- config
   logic [30:0] max_accel_ff;
   logic [30:0] max_speed_ff;
   logic [30:0] stop_radius_ff;
   logic [30:0] slow_radius_ff;
   logic [30:0] ttt_ff;
   logic [30:0] ttt_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_accel_ff   <= arst_pkg::MAX_ACCEL_RESET;
         max_speed_ff   <= arst_pkg::MAX_SPEED_RESET;
         stop_radius_ff <= arst_pkg::STOP_RADIUS_RESET;
         slow_radius_ff <= arst_pkg::SLOW_RADIUS_RESET;
         ttt_ff         <= arst_pkg::TTT_RESET;
      end else if (csr_we) begin
         unique case (arst_pkg::csr_index_type'(csr_index))
            arst_pkg::CSR_MAX_ACCEL:   max_accel_ff   <= csr_wdata;
            arst_pkg::CSR_MAX_SPEED:   max_speed_ff   <= csr_wdata;
            arst_pkg::CSR_STOP_RADIUS: stop_radius_ff <= csr_wdata;
            arst_pkg::CSR_SLOW_RADIUS: slow_radius_ff <= csr_wdata;
            arst_pkg::CSR_TTT:         ttt_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero time to target acts as the smallest step
   assign ttt_eff = (ttt_ff == '0) ? 31'd1 : ttt_ff;

   // never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------- offset stage
   arst_pkg::geo_type s1_ff, s1_in;
   arst_pkg::geo_type s2_ff, s3_ff;
   logic [2:0][63:0]  s2_sq_ff;
   logic [63:0]       s3_sum_ff;

   always_comb begin
      s1_in.v      = start && !busy && !reset;
      s1_in.off[0] = arst_pkg::sat_sub(req_goal_x, req_pos_x);
      s1_in.off[1] = arst_pkg::sat_sub(req_goal_y, req_pos_y);
      s1_in.off[2] = arst_pkg::sat_sub(req_goal_z, req_pos_z);
      s1_in.vel[0] = req_vel_x;
      s1_in.vel[1] = req_vel_y;
      s1_in.vel[2] = req_vel_z;
   end

   // squares, then their sum
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (reset) begin
         s2_ff.v <= 1'b0;
         s3_ff.v <= 1'b0;
      end else begin
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s2_sq_ff[i] <= 64'(arst_pkg::abs32(s1_ff.off[i])) *
                        64'(arst_pkg::abs32(s1_ff.off[i]));
      end
      s3_sum_ff <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
   end

   // ------------------------------------------------------ distance root
   logic [31:0]       dist_len;
   arst_pkg::geo_type dly_a_ff [arst_pkg::ROOT_STEPS];

   arst_sqrt u_dist_root (
      .clock   (clock),
      .rad_in  (s3_sum_ff),
      .root_out(dist_len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::ROOT_STEPS; k++) dly_a_ff[k].v <= 1'b0;
      end else begin
         dly_a_ff[0] <= s3_ff;
         for (int k = 1; k < arst_pkg::ROOT_STEPS; k++) dly_a_ff[k] <= dly_a_ff[k-1];
      end
   end

   // ------------------------------------------ arrival and speed numerator
   arst_pkg::speed_side_type sa_ff;
   logic [62:0]              sa_prod_ff;
   arst_pkg::geo_type        geo_a;

   assign geo_a = dly_a_ff[arst_pkg::ROOT_STEPS-1];

   always_ff @(posedge clock) begin
      sa_ff.v         <= geo_a.v && !reset;
      sa_ff.arr       <= dist_len < {1'b0, stop_radius_ff};
      sa_ff.gt_slow   <= dist_len > {1'b0, slow_radius_ff};
      sa_ff.slow_zero <= slow_radius_ff == '0;
      sa_ff.dist_len  <= dist_len;
      sa_ff.off       <= geo_a.off;
      sa_ff.vel       <= geo_a.vel;
      sa_prod_ff      <= 63'(max_speed_ff) * 63'(dist_len);
   end

   // ------------------------------------------------------- speed divide
   logic [30:0]              speed_q;
   arst_pkg::speed_side_type dly_b_ff [arst_pkg::DIV_STEPS];
   arst_pkg::speed_side_type side_b;

   arst_div u_speed_div (
      .clock  (clock),
      .num_in (sa_prod_ff),
      .den_in ({1'b0, slow_radius_ff}),
      .quo_out(speed_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::DIV_STEPS; k++) dly_b_ff[k].v <= 1'b0;
      end else begin
         dly_b_ff[0] <= sa_ff;
         for (int k = 1; k < arst_pkg::DIV_STEPS; k++) dly_b_ff[k] <= dly_b_ff[k-1];
      end
   end

   assign side_b = dly_b_ff[arst_pkg::DIV_STEPS-1];

   // target speed: full outside the slow radius, scaled inside it
   arst_pkg::speed_side_type sb_ff;
   logic [30:0]              sb_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) sb_ff.v <= 1'b0;
      else       sb_ff   <= side_b;
      priority if (side_b.gt_slow) sb_speed_ff <= max_speed_ff;
      else if (side_b.slow_zero)   sb_speed_ff <= '0;
      else                         sb_speed_ff <= speed_q;
   end

   // ------------------------------------------- desired velocity divide
   arst_pkg::want_side_type sc_ff;
   logic [2:0][62:0]        sc_prod_ff;
   logic [31:0]             sc_dist_ff;

   always_ff @(posedge clock) begin
      sc_ff.v         <= sb_ff.v && !reset;
      sc_ff.arr       <= sb_ff.arr;
      sc_ff.dist_zero <= sb_ff.dist_len == '0;
      sc_ff.vel       <= sb_ff.vel;
      sc_dist_ff      <= sb_ff.dist_len;
      for (int i = 0; i < 3; i++) begin
         sc_ff.neg[i]  <= sb_ff.off[i][31];
         sc_prod_ff[i] <= 63'(arst_pkg::abs32(sb_ff.off[i])) * 63'(sb_speed_ff);
      end
   end

   logic [2:0][30:0]        want_q;
   arst_pkg::want_side_type dly_c_ff [arst_pkg::DIV_STEPS];
   arst_pkg::want_side_type side_c;

   for (genvar g = 0; g < 3; g++) begin : g_want
      arst_div u_want_div (
         .clock  (clock),
         .num_in (sc_prod_ff[g]),
         .den_in (sc_dist_ff),
         .quo_out(want_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::DIV_STEPS; k++) dly_c_ff[k].v <= 1'b0;
      end else begin
         dly_c_ff[0] <= sc_ff;
         for (int k = 1; k < arst_pkg::DIV_STEPS; k++) dly_c_ff[k] <= dly_c_ff[k-1];
      end
   end

   assign side_c = dly_c_ff[arst_pkg::DIV_STEPS-1];

   // velocity error, 33 bits signed
   arst_pkg::err_stage_type sd_ff;

   always_ff @(posedge clock) begin
      logic [31:0] want;
      sd_ff.v   <= side_c.v && !reset;
      sd_ff.arr <= side_c.arr;
      for (int i = 0; i < 3; i++) begin
         want = side_c.dist_zero ? 32'd0 : arst_pkg::signed_q(want_q[i], side_c.neg[i]);
         sd_ff.err[i] <= {want[31], want} - {side_c.vel[i][31], side_c.vel[i]};
      end
   end

   // ----------------------------------------- time to target divide
   arst_pkg::lin_side_type se_ff;
   logic [2:0][48:0]       se_num_ff;

   always_ff @(posedge clock) begin
      logic [32:0] mag;
      logic [48:0] num;
      se_ff.v   <= sd_ff.v && !reset;
      se_ff.arr <= sd_ff.arr;
      for (int i = 0; i < 3; i++) begin
         mag = sd_ff.err[i][32] ? (33'd0 - sd_ff.err[i]) : sd_ff.err[i];
         num = {mag, 16'd0};
         se_num_ff[i] <= num;
         se_ff.neg[i] <= sd_ff.err[i][32];
         // quotient at or above 2^31 saturates
         se_ff.ovf[i] <= {13'd0, num[48:31]} >= ttt_eff;
      end
   end

   logic [2:0][30:0]       lin_q;
   arst_pkg::lin_side_type dly_d_ff [arst_pkg::DIV_STEPS];
   arst_pkg::lin_side_type side_d;

   for (genvar g = 0; g < 3; g++) begin : g_lin
      arst_div u_lin_div (
         .clock  (clock),
         .num_in ({14'd0, se_num_ff[g]}),
         .den_in ({1'b0, ttt_eff}),
         .quo_out(lin_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::DIV_STEPS; k++) dly_d_ff[k].v <= 1'b0;
      end else begin
         dly_d_ff[0] <= se_ff;
         for (int k = 1; k < arst_pkg::DIV_STEPS; k++) dly_d_ff[k] <= dly_d_ff[k-1];
      end
   end

   assign side_d = dly_d_ff[arst_pkg::DIV_STEPS-1];

   // saturated linear acceleration
   arst_pkg::lin_stage_type sf_ff;

   always_ff @(posedge clock) begin
      sf_ff.v   <= side_d.v && !reset;
      sf_ff.arr <= side_d.arr;
      for (int i = 0; i < 3; i++) begin
         if (side_d.ovf[i]) begin
            sf_ff.lin[i] <= side_d.neg[i] ? arst_pkg::SAT_NEG : arst_pkg::SAT_POS;
         end else begin
            sf_ff.lin[i] <= arst_pkg::signed_q(lin_q[i], side_d.neg[i]);
         end
      end
   end

   // --------------------------------------------- magnitude and clamp test
   arst_pkg::lin_stage_type sg_ff;
   logic [2:0][63:0]        sg_sq_ff;
   logic [61:0]             sg_amax_sq_ff;
   arst_pkg::acc_side_type  sh_ff;
   logic [63:0]             sh_ssq_ff;
   logic [63:0]             ssq;

   assign ssq = sg_sq_ff[0] + sg_sq_ff[1] + sg_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) sg_ff.v <= 1'b0;
      else       sg_ff   <= sf_ff;
      for (int i = 0; i < 3; i++) begin
         sg_sq_ff[i] <= 64'(arst_pkg::abs32(sf_ff.lin[i])) *
                        64'(arst_pkg::abs32(sf_ff.lin[i]));
      end
      sg_amax_sq_ff <= 62'(max_accel_ff) * 62'(max_accel_ff);
      sh_ff.v     <= sg_ff.v && !reset;
      sh_ff.arr   <= sg_ff.arr;
      sh_ff.lin   <= sg_ff.lin;
      sh_ff.clamp <= ssq > {2'b00, sg_amax_sq_ff};
      sh_ssq_ff   <= ssq;
   end

   logic [31:0]            accel_mag;
   arst_pkg::acc_side_type dly_e_ff [arst_pkg::ROOT_STEPS];
   arst_pkg::acc_side_type side_e;

   arst_sqrt u_mag_root (
      .clock   (clock),
      .rad_in  (sh_ssq_ff),
      .root_out(accel_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::ROOT_STEPS; k++) dly_e_ff[k].v <= 1'b0;
      end else begin
         dly_e_ff[0] <= sh_ff;
         for (int k = 1; k < arst_pkg::ROOT_STEPS; k++) dly_e_ff[k] <= dly_e_ff[k-1];
      end
   end

   assign side_e = dly_e_ff[arst_pkg::ROOT_STEPS-1];

   // ----------------------------------------------------- rescale divide
   arst_pkg::acc_side_type si_ff;
   logic [2:0][62:0]       si_prod_ff;
   logic [31:0]            si_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) si_ff.v <= 1'b0;
      else       si_ff   <= side_e;
      si_mag_ff <= accel_mag;
      for (int i = 0; i < 3; i++) begin
         si_prod_ff[i] <= 63'(arst_pkg::abs32(side_e.lin[i])) * 63'(max_accel_ff);
      end
   end

   logic [2:0][30:0]       acc_q;
   arst_pkg::acc_side_type dly_f_ff [arst_pkg::DIV_STEPS];
   arst_pkg::acc_side_type side_f;

   for (genvar g = 0; g < 3; g++) begin : g_acc
      arst_div u_acc_div (
         .clock  (clock),
         .num_in (si_prod_ff[g]),
         .den_in (si_mag_ff),
         .quo_out(acc_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arst_pkg::DIV_STEPS; k++) dly_f_ff[k].v <= 1'b0;
      end else begin
         dly_f_ff[0] <= si_ff;
         for (int k = 1; k < arst_pkg::DIV_STEPS; k++) dly_f_ff[k] <= dly_f_ff[k-1];
      end
   end

   assign side_f = dly_f_ff[arst_pkg::DIV_STEPS-1];

   // ------------------------------------------------------- result register
   logic             rsp_valid_ff;
   logic             rsp_arrived_ff;
   logic [2:0][31:0] rsp_accel_ff;

   always_ff @(posedge clock) begin
      rsp_valid_ff   <= side_f.v && !reset;
      rsp_arrived_ff <= side_f.arr;
      for (int i = 0; i < 3; i++) begin
         priority if (side_f.arr) rsp_accel_ff[i] <= '0;
         else if (side_f.clamp) begin
            rsp_accel_ff[i] <= arst_pkg::signed_q(acc_q[i], side_f.lin[i][31]);
         end else rsp_accel_ff[i] <= side_f.lin[i];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_arrived = rsp_arrived_ff;
   assign rsp_accel_x = rsp_accel_ff[0];
   assign rsp_accel_y = rsp_accel_ff[1];
   assign rsp_accel_z = rsp_accel_ff[2];

   // ------------------------------------------------------------ checks
   // every result traces back to an earlier transfer, offset by LATENCY
   `ARST_ASSERT_IMPL(a_latency, clock, reset, rsp_valid,
      $past(start && !busy, arst_pkg::LATENCY))
   // scaled target speed never exceeds the top speed
   `ARST_ASSERT_IMPL(a_speed_bound, clock, reset, sb_ff.v, sb_speed_ff <= max_speed_ff)
   // no component of a steering result exceeds the acceleration limit
   `ARST_ASSERT_IMPL(a_accel_bound, clock, reset, rsp_valid && !rsp_arrived,
      (arst_pkg::abs32(rsp_accel_x) <= {1'b0, max_accel_ff}) &&
      (arst_pkg::abs32(rsp_accel_y) <= {1'b0, max_accel_ff}) &&
      (arst_pkg::abs32(rsp_accel_z) <= {1'b0, max_accel_ff}))
   // a transfer enters the first stage
   `ARST_ASSERT_NEXT(a_enter, clock, reset, start && !busy && !reset, s1_ff.v)

endmodule

`default_nettype wire
